/* hdl/npf_pkg.sv */
// Shared types and constants for the normalized patch pixel fetch block.
// Used by every module under hdl except npf_ram; depends on nothing.
package npf_pkg;

    localparam int MAX_IMAGES   = 64;
    localparam int REC_AW       = 6;
    localparam int CNT_W        = 7;
    localparam int PIXEL_DEPTH  = 1048576;
    localparam int PIX_AW       = 20;
    localparam int FILL_W       = 21;
    localparam int MAX_DIM      = 1024;
    localparam int NUM_CHANNELS = 3;
    localparam int ADDR_W       = 25;
    localparam int QUO_W        = 21;
    localparam int DVS_W        = 11;
    localparam int IN_TDATA_W   = 88;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [2:0] REG_PAD   = 3'd0;
    localparam logic [2:0] REG_WIN_H = 3'd1;
    localparam logic [2:0] REG_WIN_W = 3'd2;
    localparam logic [2:0] REG_NORM0 = 3'd3;
    localparam logic [2:0] REG_NORM1 = 3'd4;
    localparam logic [2:0] REG_NORM2 = 3'd5;

    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_FETCH  = 2'd2,
        OP_CLASS  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_RANGE  = 2'd1,
        STAT_REJECT = 2'd2,
        STAT_SAT    = 2'd3
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [10:0] img_width_in;
        logic [10:0] img_height_in;
        logic [7:0]  img_class_in;
        logic [7:0]  pixel_byte;
        logic [23:0] window_index;
        logic [1:0]  chan;
        logic [10:0] row;
        logic [10:0] col;
    } item_t;

    typedef struct packed {
        logic [19:0] base;
        logic [10:0] width;
        logic [10:0] height;
        logic [7:0]  cls;
        logic [20:0] windows;
    } rec_t;

    typedef struct packed {
        logic [3:0]  pad_width;
        logic [10:0] window_height;
        logic [10:0] window_width;
        logic [63:0] norm0;
        logic [63:0] norm1;
        logic [63:0] norm2;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] pixel_norm;
        logic [7:0]         class_out;
        status_t            status;
    } res_t;

endpackage

/* hdl/npf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the image record table and the pixel store; no dependencies.
module npf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/npf_front.sv */
// Input side: accepts stream transactions, decodes them and queues them.
// Depends on npf_pkg.
module npf_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [npf_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [1:0]                         s_tuser,
    output logic                               q_valid,
    output npf_pkg::item_t                     q_item,
    input  logic                               q_pop
);
    npf_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    npf_pkg::item_t dec;
    logic           push, pop;

    always_comb begin
        dec.op            = npf_pkg::op_t'(s_tuser);
        dec.img_width_in  = s_tdata[10:0];
        dec.img_height_in = s_tdata[21:11];
        dec.img_class_in  = s_tdata[29:22];
        dec.pixel_byte    = s_tdata[37:30];
        dec.window_index  = s_tdata[61:38];
        dec.chan          = s_tdata[63:62];
        dec.row           = s_tdata[74:64];
        dec.col           = s_tdata[85:75];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule

/* hdl/npf_div.sv */
// Restoring divider, one quotient bit per cycle.
// Splits a local window index into row and column offsets; depends on npf_pkg.
module npf_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [npf_pkg::QUO_W-1:0]  dividend,
    input  logic [npf_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [npf_pkg::QUO_W-1:0]  quotient,
    output logic [npf_pkg::DVS_W-1:0]  remainder
);
    logic [npf_pkg::QUO_W-1:0] quo_reg;
    logic [npf_pkg::DVS_W-1:0] rem_reg, dvs_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg, done_reg;
    logic [npf_pkg::DVS_W:0]   trial;
    logic                      fits;

    assign trial = {rem_reg, quo_reg[npf_pkg::QUO_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(npf_pkg::QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[npf_pkg::QUO_W-2:0], fits};
            rem_reg <= fits ? npf_pkg::DVS_W'(trial - {1'b0, dvs_reg})
                            : trial[npf_pkg::DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

/* hdl/npf_back.sv */
// Execution side: record table, pixel store, window lookup and normalization.
// Depends on npf_pkg, npf_ram and npf_div.
module npf_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  npf_pkg::cfg_t                       cfg,
    input  logic                                q_valid,
    input  npf_pkg::item_t                      q_item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [npf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                          m_tuser
);
    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_HDR   = 15'b000000000000010,
        S_HDR2  = 15'b000000000000100,
        S_PIX   = 15'b000000000001000,
        S_WADDR = 15'b000000000010000,
        S_WCMP  = 15'b000000000100000,
        S_CHK   = 15'b000000001000000,
        S_DIV   = 15'b000000010000000,
        S_POS   = 15'b000000100000000,
        S_ADDR  = 15'b000001000000000,
        S_ADDR2 = 15'b000010000000000,
        S_RD    = 15'b000100000000000,
        S_MUL   = 15'b001000000000000,
        S_NORM  = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    state_t                       state_reg;
    npf_pkg::item_t               item_reg;
    npf_pkg::res_t                res_reg;
    logic                         mvalid_reg;
    npf_pkg::res_t                mres_reg;
    logic [npf_pkg::CNT_W-1:0]    count_reg;
    logic [npf_pkg::FILL_W-1:0]   fill_reg;
    logic [23:0]                  left_reg;
    logic                         discard_reg;
    logic [7:0]                   last_class_reg;
    logic [npf_pkg::REC_AW-1:0]   slot_reg;
    logic [23:0]                  idx_reg;
    npf_pkg::rec_t                rec_reg;
    logic [21:0]                  wh_reg;
    logic [23:0]                  win_reg;
    logic                         fneg_reg;
    logic [12:0]                  line_reg;
    logic [11:0]                  c_reg;
    logic [23:0]                  aprod_reg;
    logic [npf_pkg::ADDR_W-1:0]   addr_reg;
    logic [39:0]                  prod_reg;

    logic                         rec_we;
    npf_pkg::rec_t                rec_wdata, rec_rd;
    logic [$bits(npf_pkg::rec_t)-1:0] rec_rdata;
    logic                         pix_we;
    logic [7:0]                   pix_rdata;
    logic                         div_start, div_done;
    logic [npf_pkg::QUO_W-1:0]    div_quo;
    logic [npf_pkg::DVS_W-1:0]    div_rem;
    logic                         load;

    logic signed [12:0]           fx, fy;
    logic [23:0]                  size;
    logic                         hdr_ok;
    logic [11:0]                  row_end, col_end;
    logic                         border, stale;
    logic [10:0]                  along;
    logic [21:0]                  r_pos;
    logic [11:0]                  c_pos;
    logic [npf_pkg::ADDR_W-1:0]   addr_sum;
    logic [63:0]                  norm_sel;
    logic signed [41:0]           v;
    logic signed [33:0]           q;
    logic                         sat_hi, sat_lo;

    npf_ram #(.WIDTH($bits(npf_pkg::rec_t)), .DEPTH(npf_pkg::MAX_IMAGES)) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (count_reg[npf_pkg::REC_AW-1:0]),
        .wdata (rec_wdata),
        .raddr (slot_reg),
        .rdata (rec_rdata)
    );

    npf_ram #(.WIDTH(8), .DEPTH(npf_pkg::PIXEL_DEPTH)) u_pix_ram (
        .aclk  (aclk),
        .we    (pix_we),
        .waddr (fill_reg[npf_pkg::PIX_AW-1:0]),
        .wdata (item_reg.pixel_byte),
        .raddr (addr_reg[npf_pkg::PIX_AW-1:0]),
        .rdata (pix_rdata)
    );

    npf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (idx_reg[npf_pkg::QUO_W-1:0]),
        .divisor   (along),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign rec_rd = npf_pkg::rec_t'(rec_rdata);
    assign q_pop  = (state_reg == S_IDLE);
    assign load   = (state_reg == S_DONE) && (!mvalid_reg || m_tready);

    always_comb begin
        fx = $signed({2'b00, item_reg.img_width_in}) - $signed({2'b00, cfg.window_width})
             + 13'sd1;
        fy = $signed({2'b00, item_reg.img_height_in}) - $signed({2'b00, cfg.window_height})
             + 13'sd1;
        size   = {1'b0, wh_reg, 1'b0} + {2'b00, wh_reg};
        hdr_ok = (count_reg < npf_pkg::CNT_W'(npf_pkg::MAX_IMAGES))
              && (item_reg.img_width_in <= 11'(npf_pkg::MAX_DIM))
              && (item_reg.img_height_in <= 11'(npf_pkg::MAX_DIM))
              && !fneg_reg
              && ({1'b0, size} <= 25'(npf_pkg::FILL_W'(npf_pkg::PIXEL_DEPTH) - fill_reg));
        rec_wdata.base    = fill_reg[npf_pkg::PIX_AW-1:0];
        rec_wdata.width   = item_reg.img_width_in;
        rec_wdata.height  = item_reg.img_height_in;
        rec_wdata.cls     = item_reg.img_class_in;
        rec_wdata.windows = win_reg[20:0];
        rec_we = (state_reg == S_HDR2) && hdr_ok;
        pix_we = (state_reg == S_PIX) && (left_reg != 24'd0) && !discard_reg
              && (fill_reg < npf_pkg::FILL_W'(npf_pkg::PIXEL_DEPTH));

        row_end = {1'b0, cfg.window_height} + {8'd0, cfg.pad_width};
        col_end = {1'b0, cfg.window_width} + {8'd0, cfg.pad_width};
        border  = (item_reg.row < {7'd0, cfg.pad_width})
               || (item_reg.col < {7'd0, cfg.pad_width})
               || ({1'b0, item_reg.row} >= row_end)
               || ({1'b0, item_reg.col} >= col_end);
        stale   = ({1'b0, rec_reg.width} + 12'd1) <= {1'b0, cfg.window_width};
        along   = rec_reg.width - cfg.window_width + 11'd1;
        div_start = (state_reg == S_CHK) && !border && !stale
                 && (item_reg.chan < 2'(npf_pkg::NUM_CHANNELS));

        r_pos = {1'b0, div_quo} + {11'd0, item_reg.row} - {18'd0, cfg.pad_width};
        c_pos = {1'b0, div_rem} + {1'b0, item_reg.col} - {8'd0, cfg.pad_width};
        addr_sum = {5'd0, rec_reg.base} + {1'b0, aprod_reg} + {13'd0, c_reg};

        case (item_reg.chan)
            2'd0:    norm_sel = cfg.norm0;
            2'd1:    norm_sel = cfg.norm1;
            default: norm_sel = cfg.norm2;
        endcase
        v = $signed({2'b00, prod_reg}) - $signed({{2{norm_sel[31]}}, norm_sel[31:0], 8'd0})
            + 42'sd128;
        q = v[41:8];
        sat_hi = !q[33] && (q[32] || q[31]);
        sat_lo = q[33] && !(q[32] && q[31]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mvalid_reg  <= 1'b0;
            count_reg   <= '0;
            fill_reg    <= '0;
            left_reg    <= '0;
            discard_reg <= 1'b0;
        end else begin
            if (load) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        unique case (q_item.op)
                            npf_pkg::OP_HEADER: state_reg <= S_HDR;
                            npf_pkg::OP_PIXEL:  state_reg <= S_PIX;
                            default: begin
                                state_reg <= (count_reg == '0) ? S_DONE : S_WADDR;
                            end
                        endcase
                    end
                end
                S_HDR:   state_reg <= S_HDR2;
                S_HDR2: begin
                    left_reg    <= size;
                    discard_reg <= !hdr_ok;
                    if (hdr_ok) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_PIX: begin
                    if (left_reg != 24'd0) begin
                        left_reg <= left_reg - 24'd1;
                    end
                    if (pix_we) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_WADDR: state_reg <= S_WCMP;
                S_WCMP: begin
                    if (idx_reg < {3'd0, rec_rd.windows}) begin
                        state_reg <= (item_reg.op == npf_pkg::OP_FETCH) ? S_CHK : S_DONE;
                    end else if (({1'b0, slot_reg} + 1'b1) == count_reg) begin
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_WADDR;
                    end
                end
                S_CHK:   state_reg <= div_start ? S_DIV : S_DONE;
                S_DIV:   state_reg <= div_done ? S_POS : S_DIV;
                S_POS: begin
                    state_reg <= ((r_pos >= {11'd0, rec_reg.height})
                               || (c_pos >= {1'b0, rec_reg.width})) ? S_DONE : S_ADDR;
                end
                S_ADDR:  state_reg <= S_ADDR2;
                S_ADDR2: begin
                    state_reg <= (addr_sum >= npf_pkg::ADDR_W'(npf_pkg::PIXEL_DEPTH))
                               ? S_DONE : S_RD;
                end
                S_RD:    state_reg <= S_MUL;
                S_MUL:   state_reg <= S_NORM;
                S_NORM:  state_reg <= S_DONE;
                S_DONE: begin
                    if (load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mres_reg <= res_reg;
        end
        unique case (state_reg)
            S_IDLE: begin
                item_reg <= q_item;
                idx_reg  <= q_item.window_index;
                slot_reg <= '0;
                res_reg  <= '{pixel_norm: '0, class_out: '0,
                              status: (count_reg == '0 && (q_item.op == npf_pkg::OP_FETCH
                                       || q_item.op == npf_pkg::OP_CLASS))
                                      ? npf_pkg::STAT_RANGE : npf_pkg::STAT_OK};
            end
            S_HDR: begin
                wh_reg   <= item_reg.img_width_in * item_reg.img_height_in;
                win_reg  <= fx[11:0] * fy[11:0];
                fneg_reg <= fx[12] || fy[12];
            end
            S_HDR2: begin
                if (hdr_ok) begin
                    last_class_reg <= item_reg.img_class_in;
                end else begin
                    res_reg.status <= npf_pkg::STAT_REJECT;
                end
            end
            S_PIX: begin
                if (left_reg == 24'd0) begin
                    res_reg.status <= npf_pkg::STAT_RANGE;
                end else if (discard_reg) begin
                    res_reg.status <= npf_pkg::STAT_REJECT;
                end
            end
            S_WCMP: begin
                rec_reg <= rec_rd;
                if (idx_reg < {3'd0, rec_rd.windows}) begin
                    res_reg.class_out <= (item_reg.op == npf_pkg::OP_CLASS) ? rec_rd.cls : 8'd0;
                end else begin
                    idx_reg  <= idx_reg - {3'd0, rec_rd.windows};
                    slot_reg <= slot_reg + 1'b1;
                    if (({1'b0, slot_reg} + 1'b1) == count_reg) begin
                        if (item_reg.op == npf_pkg::OP_CLASS) begin
                            res_reg.class_out <= last_class_reg;
                        end else begin
                            res_reg.status <= npf_pkg::STAT_RANGE;
                        end
                    end
                end
            end
            S_CHK: begin
                if (item_reg.chan >= 2'(npf_pkg::NUM_CHANNELS)) begin
                    res_reg.status <= npf_pkg::STAT_RANGE;
                end else if (!border && stale) begin
                    res_reg.status <= npf_pkg::STAT_RANGE;
                end
            end
            S_POS: begin
                if ((r_pos >= {11'd0, rec_reg.height}) || (c_pos >= {1'b0, rec_reg.width})) begin
                    res_reg.status <= npf_pkg::STAT_RANGE;
                end
                line_reg <= 13'(item_reg.chan * rec_reg.height) + {2'b00, r_pos[10:0]};
                c_reg    <= c_pos;
            end
            S_ADDR:  aprod_reg <= line_reg * rec_reg.width;
            S_ADDR2: begin
                addr_reg <= addr_sum;
                if (addr_sum >= npf_pkg::ADDR_W'(npf_pkg::PIXEL_DEPTH)) begin
                    res_reg.status <= npf_pkg::STAT_RANGE;
                end
            end
            S_MUL:   prod_reg <= pix_rdata * norm_sel[63:32];
            S_NORM: begin
                if (sat_hi) begin
                    res_reg.pixel_norm <= 32'sh7FFFFFFF;
                    res_reg.status     <= npf_pkg::STAT_SAT;
                end else if (sat_lo) begin
                    res_reg.pixel_norm <= 32'sh80000000;
                    res_reg.status     <= npf_pkg::STAT_SAT;
                end else begin
                    res_reg.pixel_norm <= q[31:0];
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {mres_reg.class_out, mres_reg.pixel_norm};
    assign m_tuser  = mres_reg.status;
endmodule

/* hdl/normalized_patch_pixel_fetch_core.sv */
// Top level of the normalized patch pixel fetch block: APB registers plus
// the queued front and back. Depends on npf_pkg, npf_front and npf_back.
//
// Every input transaction yields one result transaction. A two-entry queue
// and a result register let input and output stall independently. A fetch
// or class query walks the image table one record at a time; a fetch that
// reaches the pixels then runs the bit-serial divider and goes on to
// address, pixel read and normalization. Records and pixel bytes are held
// in RAM; no clearing pass runs after reset.
module normalized_patch_pixel_fetch_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [5:0]                         paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // img_width_in[10:0], img_height_in[21:11], img_class_in[29:22],
    // pixel_byte[37:30], window_index[61:38], chan[63:62], row[74:64], col[85:75]
    input  logic [npf_pkg::IN_TDATA_W-1:0]     s_tdata,
    // op[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_norm[31:0], class_out[39:32]
    output logic [npf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [1:0]                         m_tuser
);
    npf_pkg::cfg_t  cfg_reg;
    npf_pkg::item_t q_item;
    logic           q_valid, q_pop;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pad_width     <= '0;
            cfg_reg.window_height <= 11'd32;
            cfg_reg.window_width  <= 11'd32;
            cfg_reg.norm0         <= '0;
            cfg_reg.norm1         <= '0;
            cfg_reg.norm2         <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                npf_pkg::REG_PAD:   cfg_reg.pad_width     <= pwdata[3:0];
                npf_pkg::REG_WIN_H: cfg_reg.window_height <= pwdata[10:0];
                npf_pkg::REG_WIN_W: cfg_reg.window_width  <= pwdata[10:0];
                npf_pkg::REG_NORM0: cfg_reg.norm0         <= pwdata;
                npf_pkg::REG_NORM1: cfg_reg.norm1         <= pwdata;
                npf_pkg::REG_NORM2: cfg_reg.norm2         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            npf_pkg::REG_PAD:   prdata = {60'd0, cfg_reg.pad_width};
            npf_pkg::REG_WIN_H: prdata = {53'd0, cfg_reg.window_height};
            npf_pkg::REG_WIN_W: prdata = {53'd0, cfg_reg.window_width};
            npf_pkg::REG_NORM0: prdata = cfg_reg.norm0;
            npf_pkg::REG_NORM1: prdata = cfg_reg.norm1;
            npf_pkg::REG_NORM2: prdata = cfg_reg.norm2;
            default:            prdata = '0;
        endcase
    end

    npf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    npf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule

/* hdl/npf_checker.sv */
// Port-level checks for the normalized patch pixel fetch core, bound to it.
// Depends on npf_pkg and normalized_patch_pixel_fetch_core.
module npf_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               pready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [npf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic [1:0]                         m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == npf_pkg::STAT_SAT |->
        m_tdata[31:0] == 32'h7FFFFFFF || m_tdata[31:0] == 32'h80000000)
        else $error("saturated result not at a rail");

    a_class_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[39:32] != 8'd0 |->
        m_tuser == npf_pkg::STAT_OK && m_tdata[31:0] == 32'd0)
        else $error("class with error or pixel value");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == npf_pkg::STAT_RANGE || m_tuser == npf_pkg::STAT_REJECT) |->
        m_tdata == '0)
        else $error("error result carries data");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");
endmodule

bind normalized_patch_pixel_fetch_core npf_checker u_npf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
